@@ design/sast_pkg.sv @@
`timescale 1ns / 1ps
package sast_pkg;
	localparam int NUM_AXES = 3;
endpackage

@@ design/sast_if.sv @@
`timescale 1ns / 1ps
interface sast_box_if #(parameter int COORD_BITS = 32) (input logic clk);
	logic valid;
	logic ready;
	logic signed [COORD_BITS-1:0] box_min_x, box_min_y, box_min_z;
	logic signed [COORD_BITS-1:0] box_max_x, box_max_y, box_max_z;
	logic signed [COORD_BITS-1:0] seg_origin_x, seg_origin_y, seg_origin_z;
	logic signed [COORD_BITS-1:0] seg_dir_x, seg_dir_y, seg_dir_z;
	modport source(output valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y,
		box_max_z, seg_origin_x, seg_origin_y, seg_origin_z, seg_dir_x, seg_dir_y,
		seg_dir_z, input ready);
	modport sink(input valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y,
		box_max_z, seg_origin_x, seg_origin_y, seg_origin_z, seg_dir_x, seg_dir_y,
		seg_dir_z, output ready);
endinterface

interface sast_hit_if (input logic clk);
	logic valid;
	logic ready;
	logic hit;
	modport source(output valid, hit, input ready);
	modport sink(input valid, hit, output ready);
endinterface

@@ design/segment_aabb_slab_test.sv @@
`timescale 1ns / 1ps
// Segment versus axis-aligned box test, slab method, exact arithmetic.
// Channel req (sink): one box (min/max corners) and one segment (origin and
// direction) per request, signed fixed point, COORD_BITS wide. The fraction
// scale cancels, so FRAC_BITS only documents the format.
// Channel rsp (source): one hit bit per request, in request order.
// A request passes stages s1 to s5 before rsp valid; throughput one
// request per cycle unless rsp stalls, set by the five-stage pipeline:
//   s1 slab numerators and signs, s2 per-axis near/far and flags,
//   s3 near and far cross-products (near_x*d vs near_y*d ..), s4 pick
//   entry/exit, s5 entry-vs-exit products and range flags for the decision.
// Every stage carries a valid bit; the whole pipe advances when the output
// register is empty or being taken, so a stalled receiver freezes all
// stages and nothing is dropped or repeated. req.ready = advance.
// Reset clears every valid bit; payload registers are not reset.
// Each cross product is at most (COORD_BITS+1) x (COORD_BITS+1) bits; at the
// default width a 33x33 signed multiply per compare, one stage each.
module segment_aabb_slab_test #(
	parameter int COORD_BITS = 32,
	parameter int FRAC_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	sast_box_if.sink req,
	sast_hit_if.source rsp
);
	localparam int NB = COORD_BITS + 2;
	localparam int PB = 2 * NB;
	localparam int NA = sast_pkg::NUM_AXES;
	localparam int FMT_FRAC = FRAC_BITS;

	typedef logic signed [NB-1:0] num_t;
	typedef logic signed [PB-1:0] prod_t;

	logic adv;
	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	// hold everything while the result waits
	assign adv = !v_s5 || rsp.ready;
	assign req.ready = adv;

	// stage 1: numerators
	num_t na_s1 [NA], nb_s1 [NA], d_s1 [NA];
	logic signed [COORD_BITS-1:0] bmin [NA], bmax [NA], org [NA], dir [NA];
	always_comb begin
		bmin[0] = req.box_min_x; bmin[1] = req.box_min_y; bmin[2] = req.box_min_z;
		bmax[0] = req.box_max_x; bmax[1] = req.box_max_y; bmax[2] = req.box_max_z;
		org[0] = req.seg_origin_x; org[1] = req.seg_origin_y; org[2] = req.seg_origin_z;
		dir[0] = req.seg_dir_x; dir[1] = req.seg_dir_y; dir[2] = req.seg_dir_z;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < NA; k++) begin
				na_s1[k] <= NB'(bmin[k]) - NB'(org[k]);
				nb_s1[k] <= NB'(bmax[k]) - NB'(org[k]);
				d_s1[k] <= NB'(dir[k]);
			end
		end
	end

	// stage 2: flip to positive direction, near/far, flags
	num_t nr_s2 [NA], fr_s2 [NA], d_s2 [NA];
	logic [NA-1:0] act_s2;
	logic onp_s2, miss_s2;
	always_ff @(posedge clk) begin
		if (adv) begin
			logic onp, ms;
			num_t a, b;
			onp = 1'b0;
			ms = 1'b0;
			for (int k = 0; k < NA; k++) begin
				a = d_s1[k][NB-1] ? -na_s1[k] : na_s1[k];
				b = d_s1[k][NB-1] ? -nb_s1[k] : nb_s1[k];
				act_s2[k] <= d_s1[k] != '0;
				d_s2[k] <= d_s1[k][NB-1] ? -d_s1[k] : d_s1[k];
				nr_s2[k] <= (a < b) ? a : b;
				fr_s2[k] <= (a < b) ? b : a;
				if (d_s1[k] == '0) begin
					if (na_s1[k] == '0 || nb_s1[k] == '0)
						onp = 1'b1;
					else if (na_s1[k][NB-1] == nb_s1[k][NB-1])
						ms = 1'b1;
				end
			end
			onp_s2 <= onp;
			miss_s2 <= ms;
		end
	end

	// stage 3: pairwise cross products n_i*d_j for near and far
	prod_t pn_s3 [NA][NA], pf_s3 [NA][NA];
	num_t nr_s3 [NA], fr_s3 [NA], d_s3 [NA];
	logic [NA-1:0] act_s3;
	logic onp_s3, miss_s3;
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < NA; i++)
				for (int j = 0; j < NA; j++) begin
					pn_s3[i][j] <= PB'(nr_s2[i]) * PB'(d_s2[j]);
					pf_s3[i][j] <= PB'(fr_s2[i]) * PB'(d_s2[j]);
				end
			nr_s3 <= nr_s2; fr_s3 <= fr_s2; d_s3 <= d_s2;
			act_s3 <= act_s2; onp_s3 <= onp_s2; miss_s3 <= miss_s2;
		end
	end

	// stage 4: select entry (largest near) and exit (smallest far)
	num_t lo_n_s4, lo_d_s4, hi_n_s4, hi_d_s4;
	logic lo_inf_s4, hi_inf_s4, onp_s4, miss_s4;
	always_ff @(posedge clk) begin
		if (adv) begin
			logic li, hi;
			logic [1:0] lk, hk;
			li = 1'b1; hi = 1'b1; lk = '0; hk = '0;
			for (int k = 0; k < NA; k++) begin
				if (act_s3[k]) begin
					// near_k/d_k > near_lk/d_lk  <=> near_k*d_lk > near_lk*d_k
					if (li || pn_s3[k][lk] > pn_s3[lk][k]) begin
						li = 1'b0; lk = 2'(k);
					end
					if (hi || pf_s3[k][hk] < pf_s3[hk][k]) begin
						hi = 1'b0; hk = 2'(k);
					end
				end
			end
			lo_inf_s4 <= li; hi_inf_s4 <= hi;
			lo_n_s4 <= nr_s3[lk]; lo_d_s4 <= d_s3[lk];
			hi_n_s4 <= fr_s3[hk]; hi_d_s4 <= d_s3[hk];
			onp_s4 <= onp_s3; miss_s4 <= miss_s3;
		end
	end

	// stage 5: entry-vs-exit cross product and range flags
	prod_t pl_s5, ph_s5;
	logic lo_inf_s5, hi_inf_s5, onp_s5, miss_s5;
	logic min_lt0_s5, max_lt0_s5, min_gt1_s5, max_gt1_s5;
	always_ff @(posedge clk) begin
		if (adv) begin
			pl_s5 <= PB'(lo_n_s4) * PB'(hi_d_s4);
			ph_s5 <= PB'(hi_n_s4) * PB'(lo_d_s4);
			lo_inf_s5 <= lo_inf_s4; hi_inf_s5 <= hi_inf_s4;
			onp_s5 <= onp_s4; miss_s5 <= miss_s4;
			min_lt0_s5 <= lo_inf_s4 || lo_n_s4[NB-1];
			max_lt0_s5 <= !hi_inf_s4 && hi_n_s4[NB-1];
			min_gt1_s5 <= !lo_inf_s4 && (lo_n_s4 > lo_d_s4);
			max_gt1_s5 <= hi_inf_s4 || (hi_n_s4 > hi_d_s4);
		end
	end

	always_comb begin
		if (onp_s5)
			rsp.hit = 1'b1;
		else if (miss_s5)
			rsp.hit = 1'b0;
		else if ((min_lt0_s5 && max_lt0_s5) || (min_gt1_s5 && max_gt1_s5))
			rsp.hit = 1'b0;
		else
			rsp.hit = lo_inf_s5 || hi_inf_s5 || (pl_s5 < ph_s5);
	end

	// advance the valid bits with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0; v_s5 <= 1'b0;
		end else if (adv) begin
			v_s1 <= req.valid; v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= v_s3; v_s5 <= v_s4;
		end
	end
	assign rsp.valid = v_s5;

`ifndef SYNTHESIS
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.hit))
		else $error("result changed under stall");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp.valid |-> req.ready)
		else $error("request blocked with empty output");
	a_onplane: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && onp_s5 |-> rsp.hit)
		else $error("on-plane case not a hit");
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready && rsp.ready ##1 rsp.ready ##1 rsp.ready ##1 rsp.ready
		##1 rsp.ready |=> rsp.valid)
		else $error("result missing after five cycles");
`endif
endmodule

@@ test/segment_aabb_slab_test_tb.sv @@
`timescale 1ns / 1ps
module segment_aabb_slab_test_tb;
	localparam int CB = 32;
	localparam int FB = 16;
	localparam int N_RANDOM = 1830;
	localparam logic [31:0] ONE = 32'h0001_0000;
	localparam logic [31:0] MAXV = 32'h7fff_ffff;
	localparam logic [31:0] MINV = 32'h8000_0000;

	// One request: box min (x,y,z), box max, origin, direction.
	typedef struct packed {
		logic [CB-1:0] bmin_x, bmin_y, bmin_z;
		logic [CB-1:0] bmax_x, bmax_y, bmax_z;
		logic [CB-1:0] org_x, org_y, org_z;
		logic [CB-1:0] dir_x, dir_y, dir_z;
	} seg_box_t;

	// Directed row: request plus an optional hand-typed answer.
	typedef struct {
		seg_box_t q;
		bit known;
		bit hit;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int errors = 0;
	int hits_seen = 0;
	int misses_seen = 0;
	int stall_left = 0;
	bit quiet = 1'b0;
	bit sending_done = 1'b0;
	bit expected_hits[$];
	bit known_hits[$];
	bit known_flag[$];

	sast_box_if #(.COORD_BITS(CB)) req(clk);
	sast_hit_if rsp(clk);

	segment_aabb_slab_test #(.COORD_BITS(CB), .FRAC_BITS(FB)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req.sink),
		.rsp(rsp.source)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Hard stop well past the slowest legal run.
	initial begin
		#5_000_000;
		$display("Verification failed");
		$finish;
	end

	// Sign of a/b - c/e for positive b and e; exact with 128-bit products.
	function automatic int frac_cmp(longint a, longint b, longint c, longint e);
		logic signed [127:0] l;
		logic signed [127:0] r;
		begin
			l = 128'(signed'(a)) * 128'(signed'(e));
			r = 128'(signed'(c)) * 128'(signed'(b));
			return (l > r) ? 1 : ((l < r) ? -1 : 0);
		end
	endfunction

	// Slab test on one request: entry/exit kept as exact fractions.
	function automatic bit slab_hit(seg_box_t q);
		longint bmin[3], bmax[3], org[3], dir[3];
		longint na, nb, d, nr, fr;
		longint lo_n, lo_d, hi_n, hi_d;
		bit lo_inf, hi_inf, on_plane, axis_miss;
		bit min_lt0, max_lt0, min_gt1, max_gt1;
		begin
			bmin = '{longint'(signed'(q.bmin_x)), longint'(signed'(q.bmin_y)),
				longint'(signed'(q.bmin_z))};
			bmax = '{longint'(signed'(q.bmax_x)), longint'(signed'(q.bmax_y)),
				longint'(signed'(q.bmax_z))};
			org = '{longint'(signed'(q.org_x)), longint'(signed'(q.org_y)),
				longint'(signed'(q.org_z))};
			dir = '{longint'(signed'(q.dir_x)), longint'(signed'(q.dir_y)),
				longint'(signed'(q.dir_z))};
			lo_inf = 1; hi_inf = 1; on_plane = 0; axis_miss = 0;
			lo_n = 0; lo_d = 1; hi_n = 0; hi_d = 1;
			for (int k = 0; k < sast_pkg::NUM_AXES; k++) begin
				na = bmin[k] - org[k];
				nb = bmax[k] - org[k];
				d = dir[k];
				if (d == 0) begin
					// parallel axis: on a plane wins, outside both planes misses
					if (na == 0 || nb == 0) on_plane = 1;
					else if ((na < 0) == (nb < 0)) axis_miss = 1;
					continue;
				end
				if (d < 0) begin
					na = -na; nb = -nb; d = -d;
				end
				nr = (na < nb) ? na : nb;
				fr = (na < nb) ? nb : na;
				if (lo_inf || frac_cmp(nr, d, lo_n, lo_d) > 0) begin
					lo_inf = 0; lo_n = nr; lo_d = d;
				end
				if (hi_inf || frac_cmp(fr, d, hi_n, hi_d) < 0) begin
					hi_inf = 0; hi_n = fr; hi_d = d;
				end
			end
			if (on_plane) return 1'b1;
			if (axis_miss) return 1'b0;
			min_lt0 = lo_inf || lo_n < 0;
			max_lt0 = !hi_inf && hi_n < 0;
			min_gt1 = !lo_inf && lo_n > lo_d;
			max_gt1 = hi_inf || hi_n > hi_d;
			if ((min_lt0 && max_lt0) || (min_gt1 && max_gt1)) return 1'b0;
			return lo_inf || hi_inf || frac_cmp(lo_n, lo_d, hi_n, hi_d) < 0;
		end
	endfunction

	function automatic seg_box_t mk(logic [CB-1:0] lx, ly, lz, hx, hy, hz,
			ox, oy, oz, dx, dy, dz);
		seg_box_t q;
		begin
			q = '{lx, ly, lz, hx, hy, hz, ox, oy, oz, dx, dy, dz};
			return q;
		end
	endfunction

	// Coordinate picker: mostly small values near the box, sometimes extremes.
	function automatic logic [CB-1:0] pick_coord();
		case ($urandom_range(0, 9))
			0: return $urandom();
			1: return $urandom_range(0, 1) ? MAXV : MINV;
			2: return 32'(signed'($urandom_range(0, 8)) - 4) <<< FB;
			default: return 32'(signed'($urandom_range(0, 20 * ONE)) - 10 * signed'(ONE));
		endcase
	endfunction

	function automatic logic [CB-1:0] pick_dir();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return $urandom();
			2: return $urandom_range(0, 1) ? MAXV : MINV;
			default: return 32'(signed'($urandom_range(0, 40 * ONE)) - 20 * signed'(ONE));
		endcase
	endfunction

	// Box mostly well-formed (min <= max, x sometimes inverted) with a segment aimed near it; sometimes noise.
	function automatic seg_box_t random_request();
		seg_box_t q;
		logic [CB-1:0] a, b;
		begin
			if ($urandom_range(0, 9) == 0) begin
				q = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
					$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
				return q;
			end
			a = pick_coord(); b = pick_coord();
			if (signed'(a) > signed'(b) && $urandom_range(0, 7) != 0) {a, b} = {b, a};
			q.bmin_x = a; q.bmax_x = b;
			a = pick_coord(); b = pick_coord();
			if (signed'(a) > signed'(b)) {a, b} = {b, a};
			q.bmin_y = a; q.bmax_y = b;
			a = pick_coord(); b = pick_coord();
			if (signed'(a) > signed'(b)) {a, b} = {b, a};
			q.bmin_z = a; q.bmax_z = b;
			// occasionally put the origin right on a plane
			q.org_x = ($urandom_range(0, 9) == 0) ? q.bmin_x : pick_coord();
			q.org_y = ($urandom_range(0, 9) == 0) ? q.bmax_y : pick_coord();
			q.org_z = pick_coord();
			q.dir_x = pick_dir(); q.dir_y = pick_dir(); q.dir_z = pick_dir();
			return q;
		end
	endfunction

	task automatic send(seg_box_t q, bit known, bit hit);
		begin
			{req.box_min_x, req.box_min_y, req.box_min_z, req.box_max_x, req.box_max_y,
				req.box_max_z, req.seg_origin_x, req.seg_origin_y, req.seg_origin_z,
				req.seg_dir_x, req.seg_dir_y, req.seg_dir_z} <= q;
			req.valid <= 1'b1;
			expected_hits.push_back(slab_hit(q));
			known_flag.push_back(known);
			known_hits.push_back(hit);
			do @(posedge clk); while (!req.ready);
			// random idle burst after the request is taken
			if (!quiet && $urandom_range(0, 5) == 0) begin
				req.valid <= 1'b0;
				repeat ($urandom_range(1, 14)) @(posedge clk);
			end
		end
	endtask

	// Stimulus: reset, directed table, then random requests.
	initial begin
		row_t rows[$];
		seg_box_t u;
		u = mk(0, 0, 0, ONE, ONE, ONE, 0, 0, 0, 0, 0, 0);
		req.valid <= 1'b0;
		{req.box_min_x, req.box_min_y, req.box_min_z, req.box_max_x, req.box_max_y,
			req.box_max_z, req.seg_origin_x, req.seg_origin_y, req.seg_origin_z,
			req.seg_dir_x, req.seg_dir_y, req.seg_dir_z} <= '0;
		// straight through a unit box
		rows.push_back('{mk(0, 0, 0, ONE, ONE, ONE, -ONE, ONE / 2, ONE / 2,
			3 * ONE, 0, 0), 1, 1});
		// stops short of the box
		rows.push_back('{mk(0, 0, 0, ONE, ONE, ONE, -3 * ONE, ONE / 2, ONE / 2,
			ONE, 0, 0), 1, 0});
		// starts past the box
		rows.push_back('{mk(0, 0, 0, ONE, ONE, ONE, 3 * ONE, ONE / 2, ONE / 2,
			ONE, 0, 0), 1, 0});
		// fully inside, zero direction: no axis constrains
		rows.push_back('{mk(0, 0, 0, ONE, ONE, ONE, ONE / 2, ONE / 2, ONE / 2,
			0, 0, 0), 1, 1});
		// zero y direction, outside on y
		rows.push_back('{mk(0, 0, 0, ONE, ONE, ONE, ONE / 2, 2 * ONE, ONE / 2,
			ONE, 0, 0), 1, 0});
		// zero direction on a plane wins even though x misses
		rows.push_back('{mk(0, 0, 0, ONE, ONE, ONE, 5 * ONE, ONE, ONE / 2,
			ONE, 0, 0), 1, 1});
		// negative direction through the box
		rows.push_back('{mk(0, 0, 0, ONE, ONE, ONE, 2 * ONE, ONE / 2, ONE / 2,
			-3 * ONE, 0, 0), 1, 1});
		// diagonal grazing an edge, inverted box, degenerate and extreme boxes: predictor
		rows.push_back('{mk(0, 0, 0, ONE, ONE, ONE, -ONE, 0, ONE / 2,
			ONE, ONE, 0), 0, 0});
		rows.push_back('{mk(ONE, ONE, ONE, 0, 0, 0, -ONE, ONE / 2, ONE / 2,
			3 * ONE, 0, 0), 0, 0});
		rows.push_back('{mk(0, 0, 0, 0, 0, 0, -ONE, -ONE, -ONE,
			2 * ONE, 2 * ONE, 2 * ONE), 0, 0});
		rows.push_back('{mk(MINV, MINV, MINV, MAXV, MAXV, MAXV, MAXV, MINV, 0,
			MINV, MAXV, MAXV), 0, 0});
		rows.push_back('{mk(MAXV, MAXV, MAXV, MINV, MINV, MINV, MINV, MAXV, MINV,
			MAXV, MINV, MAXV), 0, 0});
		rows.push_back('{mk(MINV, MINV, MINV, MAXV, MAXV, MAXV, 0, 0, 0,
			MINV, MINV, MINV), 0, 0});
		rows.push_back('{mk('1, '1, '1, '1, '1, '1, '1, '1, '1, '1, '1, '1), 0, 0});
		rows.push_back('{u, 0, 0});
		rows.push_back('{mk(0, 0, 0, ONE, ONE, ONE, ONE / 2, -ONE, ONE / 2,
			ONE, 2 * ONE, 3), 0, 0});
		rows.push_back('{mk(0, 0, 0, ONE, ONE, ONE, -ONE, -ONE, -ONE,
			ONE, ONE, ONE), 0, 0});

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (rows[i]) send(rows[i].q, rows[i].known, rows[i].hit);
		for (int n = 0; n < N_RANDOM; n++) begin
			if (n > N_RANDOM - 200) quiet = 1'b1;
			send(random_request(), 0, 0);
		end
		req.valid <= 1'b0;
		sending_done = 1'b1;
	end

	// Receiver: random stall bursts, stalls off near the end.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
			stall_left = 0;
		end else if (quiet) begin
			rsp.ready <= 1'b1;
		end else if (stall_left != 0) begin
			stall_left = stall_left - 1;
			rsp.ready <= (stall_left == 0);
		end else if ($urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(1, 14);
			rsp.ready <= 1'b0;
		end else begin
			rsp.ready <= 1'b1;
		end
	end

	// Check each taken response against the oldest expectation.
	always @(posedge clk) begin
		bit want;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (expected_hits.size() == 0) begin
				$display("%0t: unexpected response, expected none, actual hit=%0b",
					$realtime, rsp.hit);
				errors++;
			end else begin
				want = expected_hits.pop_front();
				if (known_flag.pop_front() && known_hits[0] != want) begin
					$display("%0t: table row disagrees, expected %0b, predicted %0b",
						$realtime, known_hits[0], want);
					errors++;
				end
				void'(known_hits.pop_front());
				if (rsp.hit !== want) begin
					$display("%0t: hit mismatch, expected %0b, actual %0b",
						$realtime, want, rsp.hit);
					errors++;
				end
				if (want) hits_seen++;
				else misses_seen++;
			end
		end
	end

	// Drain, then settle past the pipeline depth and report.
	initial begin
		wait (sending_done);
		while (expected_hits.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		$display("Checked %0d segment/box tests: %0d hits, %0d misses.",
			hits_seen + misses_seen, hits_seen, misses_seen);
		if (errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end
endmodule

@@ files.f @@
design/sast_pkg.sv
design/sast_if.sv
design/segment_aabb_slab_test.sv
test/segment_aabb_slab_test_tb.sv
